### hdl/rdq_pkg.sv
package rdq_pkg;

  // Request kind codes carried on in_tuser
  localparam int unsigned KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_ADD_BACK   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD_FRONT  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DROP_BACK  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DROP_FRONT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DELETE     = 3'd5;
  localparam logic [KIND_W-1:0] KIND_READ       = 3'd6;

  // Result status codes
  localparam int unsigned STATUS_W = 2;
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OUT_RANGE = 2'd2;

endpackage

### hdl/rdq_ram.sv
module rdq_ram #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_WIDTH-1:0]    wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_WIDTH-1:0]    rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, hold data when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/rdq_ring_add.sv
module rdq_ring_add #(
  parameter int unsigned DEPTH = 16
) (
  input  logic [$clog2(DEPTH)-1:0]   base,
  input  logic [$clog2(DEPTH+1)-1:0] off,
  input  logic [$clog2(DEPTH+1)-1:0] cap,
  output logic [$clog2(DEPTH)-1:0]   sum
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH+1);
  localparam int unsigned SUM_W = CNT_W + 1;

  logic [SUM_W-1:0] raw;
  logic [SUM_W-1:0] wrapped;

  // Add and wrap once: base is below cap and off at most cap
  always_comb begin
    raw = SUM_W'(base) + SUM_W'(off);
    if (raw >= SUM_W'(cap)) begin
      wrapped = raw - SUM_W'(cap);
    end else begin
      wrapped = raw;
    end
  end

  assign sum = wrapped[IDX_W-1:0];

endmodule

### hdl/ring_deque_with_positional_insert.sv
// Push, pop, read and unused kinds go from S_IDLE to S_FIN, which loads the result register
// once it is free; the next request is taken only when S_FIN has returned to S_IDLE.
// Insert and delete moving n entries (n up to DEPTH-1) step through S_SHIFT, then S_FIN;
// each moved entry goes through the single ring-index adder and the RAM read and write ports.
// Reset (synchronous, rst_n low) empties the ring and sets the capacity to DEPTH;
// the entry store is not cleared and needs no clearing pass.
module ring_deque_with_positional_insert #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  // configuration: capacity_in_use
  input  logic                                      cfg_wr_en,
  input  logic [$clog2(DEPTH+1)-1:0]                cfg_wr_data,
  // request channel
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // value, position, zero fill
  input  logic [((DATA_WIDTH+$clog2(DEPTH+1)+7)/8)*8-1:0] in_tdata,
  // kind
  input  logic [rdq_pkg::KIND_W-1:0]                in_tuser,
  // result channel
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  // read_data, fill_count, is_empty, is_full, status, zero fill
  output logic [((DATA_WIDTH+$clog2(DEPTH+1)+4+7)/8)*8-1:0] out_tdata
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH+1);
  localparam int unsigned OUT_W = ((DATA_WIDTH + CNT_W + 4 + 7) / 8) * 8;
  localparam int unsigned RES_W = DATA_WIDTH + CNT_W + 2 + rdq_pkg::STATUS_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_FIN
  } state_t;

  state_t                        state_r, state_nxt;
  logic [CNT_W-1:0]              cap_r, cap_nxt;
  logic [IDX_W-1:0]              front_r, front_nxt;
  logic [IDX_W-1:0]              back_r, back_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [IDX_W-1:0]              n_r, n_nxt;
  logic                          pend_r, pend_nxt;
  logic                          ins_r, ins_nxt;
  logic                          rd_sel_r, rd_sel_nxt;
  logic                          out_tvalid_r, out_tvalid_nxt;

  logic [IDX_W-1:0]              a_r, a_nxt;
  logic [IDX_W-1:0]              wa_r, wa_nxt;
  logic [DATA_WIDTH-1:0]         val_r, val_nxt;
  logic [rdq_pkg::STATUS_W-1:0]  st_r, st_nxt;

  logic [DATA_WIDTH-1:0]         out_rd_r, out_rd_nxt;
  logic [CNT_W-1:0]              out_fill_r, out_fill_nxt;
  logic                          out_empty_r, out_empty_nxt;
  logic                          out_full_r, out_full_nxt;
  logic [rdq_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;

  logic [rdq_pkg::KIND_W-1:0]    in_kind;
  logic [DATA_WIDTH-1:0]         in_value;
  logic [CNT_W-1:0]              in_pos;
  logic                          in_fire;
  logic                          is_full;
  logic [CNT_W-1:0]              cap_less_one;
  logic [CNT_W-1:0]              ins_pos;
  logic [CNT_W-1:0]              shift_len;

  logic [IDX_W-1:0]              unit_base;
  logic [CNT_W-1:0]              unit_off;
  logic [IDX_W-1:0]              unit_sum;

  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  logic [DATA_WIDTH-1:0]         ram_wdata;
  logic                          ram_re;
  logic [IDX_W-1:0]              ram_raddr;
  logic [DATA_WIDTH-1:0]         ram_rdata;

  logic [CNT_W:0]                chk_sum;
  logic [CNT_W:0]                chk_wrap;

  // Unpack the request
  assign in_value  = in_tdata[DATA_WIDTH-1:0];
  assign in_pos    = in_tdata[DATA_WIDTH +: CNT_W];
  assign in_kind   = in_tuser;
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign is_full      = (cnt_r >= cap_r);
  assign cap_less_one = cap_r - CNT_W'(1);

  // Shared ring-index adder
  rdq_ring_add #(
    .DEPTH (DEPTH)
  ) u_ring_add (
    .base (unit_base),
    .off  (unit_off),
    .cap  (cap_r),
    .sum  (unit_sum)
  );

  // Entry store
  rdq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer next-state logic
  always_comb begin
    state_nxt      = state_r;
    cap_nxt        = cap_r;
    front_nxt      = front_r;
    back_nxt       = back_r;
    cnt_nxt        = cnt_r;
    n_nxt          = n_r;
    pend_nxt       = pend_r;
    ins_nxt        = ins_r;
    rd_sel_nxt     = rd_sel_r;
    out_tvalid_nxt = out_tvalid_r;
    a_nxt          = a_r;
    wa_nxt         = wa_r;
    val_nxt        = val_r;
    st_nxt         = st_r;
    out_rd_nxt     = out_rd_r;
    out_fill_nxt   = out_fill_r;
    out_empty_nxt  = out_empty_r;
    out_full_nxt   = out_full_r;
    out_status_nxt = out_status_r;

    unit_base = front_r;
    unit_off  = '0;
    ram_we    = 1'b0;
    ram_waddr = back_r;
    ram_wdata = in_value;
    ram_re    = 1'b0;
    ram_raddr = unit_sum;
    ins_pos   = '0;
    shift_len = '0;

    // Drop the result once taken
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    // Capacity write: clamp and empty the ring
    if (cfg_wr_en) begin
      if (cfg_wr_data == '0) begin
        cap_nxt = CNT_W'(1);
      end else if (cfg_wr_data > CNT_W'(DEPTH)) begin
        cap_nxt = CNT_W'(DEPTH);
      end else begin
        cap_nxt = cfg_wr_data;
      end
      front_nxt = '0;
      back_nxt  = '0;
      cnt_nxt   = '0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          st_nxt     = rdq_pkg::ST_OK;
          rd_sel_nxt = 1'b0;
          state_nxt  = S_FIN;
          unique case (in_kind)
            rdq_pkg::KIND_ADD_BACK: begin
              unit_base = back_r;
              unit_off  = CNT_W'(1);
              ram_we    = 1'b1;
              ram_waddr = back_r;
              back_nxt  = unit_sum;
              // full ring: front sits on back, so both advance together
              if (is_full) begin
                front_nxt = unit_sum;
              end else begin
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            rdq_pkg::KIND_ADD_FRONT: begin
              unit_base = front_r;
              unit_off  = cap_less_one;
              ram_we    = 1'b1;
              ram_waddr = unit_sum;
              front_nxt = unit_sum;
              if (is_full) begin
                back_nxt = unit_sum;
              end else begin
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            rdq_pkg::KIND_DROP_BACK: begin
              unit_base = back_r;
              unit_off  = cap_less_one;
              if (cnt_r == '0) begin
                st_nxt = rdq_pkg::ST_EMPTY;
              end else begin
                back_nxt = unit_sum;
                cnt_nxt  = cnt_r - CNT_W'(1);
              end
            end
            rdq_pkg::KIND_DROP_FRONT: begin
              unit_base = front_r;
              unit_off  = CNT_W'(1);
              if (cnt_r == '0) begin
                st_nxt = rdq_pkg::ST_EMPTY;
              end else begin
                front_nxt = unit_sum;
                cnt_nxt   = cnt_r - CNT_W'(1);
              end
            end
            rdq_pkg::KIND_INSERT: begin
              unit_base = front_r;
              unit_off  = CNT_W'(1);
              if (in_pos > cnt_r) begin
                st_nxt = rdq_pkg::ST_OUT_RANGE;
              end else begin
                // full ring: drop the front first and shift the position down
                if (is_full) begin
                  front_nxt = unit_sum;
                  cnt_nxt   = cnt_r - CNT_W'(1);
                  ins_pos   = (in_pos == '0) ? '0 : in_pos - CNT_W'(1);
                  shift_len = cnt_r - CNT_W'(1) - ins_pos;
                end else begin
                  ins_pos   = in_pos;
                  shift_len = cnt_r - in_pos;
                end
                n_nxt     = shift_len[IDX_W-1:0];
                a_nxt     = back_r;
                val_nxt   = in_value;
                ins_nxt   = 1'b1;
                pend_nxt  = 1'b0;
                state_nxt = S_SHIFT;
              end
            end
            rdq_pkg::KIND_DELETE: begin
              unit_base = front_r;
              unit_off  = in_pos;
              if (cnt_r == '0) begin
                st_nxt = rdq_pkg::ST_EMPTY;
              end else if (in_pos >= cnt_r) begin
                st_nxt = rdq_pkg::ST_OUT_RANGE;
              end else begin
                shift_len = cnt_r - CNT_W'(1) - in_pos;
                n_nxt     = shift_len[IDX_W-1:0];
                a_nxt     = unit_sum;
                ins_nxt   = 1'b0;
                pend_nxt  = 1'b0;
                state_nxt = S_SHIFT;
              end
            end
            rdq_pkg::KIND_READ: begin
              unit_base = front_r;
              unit_off  = in_pos;
              if (in_pos >= cnt_r) begin
                st_nxt = rdq_pkg::ST_OUT_RANGE;
              end else begin
                ram_re     = 1'b1;
                rd_sel_nxt = 1'b1;
              end
            end
            default: begin
              // unused kind: report current state
            end
          endcase
        end
      end

      S_SHIFT: begin
        // Write back the entry read in the previous cycle
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = wa_r;
          ram_wdata = ram_rdata;
        end
        if (n_r != '0) begin
          // Step the cursor: down for insert, up for delete
          unit_base = a_r;
          unit_off  = ins_r ? cap_less_one : CNT_W'(1);
          ram_re    = 1'b1;
          wa_nxt    = a_r;
          a_nxt     = unit_sum;
          pend_nxt  = 1'b1;
          n_nxt     = n_r - IDX_W'(1);
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          // Place the new entry (insert only) and move the back index
          unit_base = back_r;
          unit_off  = ins_r ? CNT_W'(1) : cap_less_one;
          back_nxt  = unit_sum;
          if (ins_r) begin
            ram_we    = 1'b1;
            ram_waddr = a_r;
            ram_wdata = val_r;
            cnt_nxt   = cnt_r + CNT_W'(1);
          end else begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        // Load the result once the output register is free
        if (!out_tvalid_r || out_tready) begin
          out_rd_nxt     = rd_sel_r ? ram_rdata : '0;
          out_fill_nxt   = cnt_r;
          out_empty_nxt  = (cnt_r == '0);
          out_full_nxt   = (cnt_r == cap_r);
          out_status_nxt = st_r;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cap_r        <= CNT_W'(DEPTH);
      front_r      <= '0;
      back_r       <= '0;
      cnt_r        <= '0;
      n_r          <= '0;
      pend_r       <= 1'b0;
      ins_r        <= 1'b0;
      rd_sel_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cap_r        <= cap_nxt;
      front_r      <= front_nxt;
      back_r       <= back_nxt;
      cnt_r        <= cnt_nxt;
      n_r          <= n_nxt;
      pend_r       <= pend_nxt;
      ins_r        <= ins_nxt;
      rd_sel_r     <= rd_sel_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    a_r          <= a_nxt;
    wa_r         <= wa_nxt;
    val_r        <= val_nxt;
    st_r         <= st_nxt;
    out_rd_r     <= out_rd_nxt;
    out_fill_r   <= out_fill_nxt;
    out_empty_r  <= out_empty_nxt;
    out_full_r   <= out_full_nxt;
    out_status_r <= out_status_nxt;
  end

  // Pack the result
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_W'(RES_W'({out_status_r, out_full_r, out_empty_r,
                                     out_fill_r, out_rd_r}));

  // Expected back index from front and count
  assign chk_sum  = (CNT_W+1)'(front_r) + (CNT_W+1)'(cnt_r);
  assign chk_wrap = (chk_sum >= (CNT_W+1)'(cap_r)) ? chk_sum - (CNT_W+1)'(cap_r) : chk_sum;

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cap_r != '0) && (cap_r <= CNT_W'(DEPTH)) && (cnt_r <= cap_r))
    else $error("element count or capacity out of range");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W'(front_r) < cap_r) && (CNT_W'(back_r) < cap_r))
    else $error("ring index beyond capacity");

  a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    chk_wrap[IDX_W-1:0] == back_r)
    else $error("back index does not match front plus count");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && (out_status_r == rdq_pkg::ST_EMPTY) |-> (out_fill_r == '0))
    else $error("empty status with elements held");

endmodule

### tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  localparam int unsigned IN_W        = ((DATA_W + CNT_W + 7) / 8) * 8;
  localparam int unsigned OUT_W       = ((DATA_W + CNT_W + 4 + 7) / 8) * 8;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE      = DEPTH + 8;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PHASE_ITEMS = 235;
  // capacity written at the start of each random phase, phase 0 in the lowest bits
  localparam logic [8*CNT_W-1:0] PHASE_CAPS =
    {5'd11, 5'd16, 5'd0, 5'd7, 5'd2, 5'd31, 5'd1, 5'd16};

  localparam logic [rdq_pkg::KIND_W-1:0] KIND_UNUSED = 3'd7;

  typedef struct packed {
    logic [rdq_pkg::KIND_W-1:0] kind;
    logic [DATA_W-1:0]          value;
    logic [CNT_W-1:0]           position;
  } deque_request_t;

  typedef struct packed {
    logic [DATA_W-1:0]            read_data;
    logic [CNT_W-1:0]             fill_count;
    logic                         is_empty;
    logic                         is_full;
    logic [rdq_pkg::STATUS_W-1:0] status;
  } deque_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_wr_en = 1'b0;
  logic [CNT_W-1:0]           cfg_wr_data = '0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [IN_W-1:0]            in_tdata = '0;
  logic [rdq_pkg::KIND_W-1:0] in_tuser = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [OUT_W-1:0]           out_tdata;

  // requests waiting to be offered, and results still owed by the block
  deque_request_t pending_requests[$];
  deque_result_t  awaited_results[$];
  deque_request_t on_offer;

  // predicted contents of the deque, front first
  logic [DATA_W-1:0] deque_contents[$];
  int unsigned       ring_capacity = DEPTH;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_request = 1'b0;
  bit          hold_seen;
  int unsigned hold_left;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  ring_deque_with_positional_insert #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_W)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // value, position, zero fill
    .in_tuser   (in_tuser),   // kind
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)   // read_data, fill_count, is_empty, is_full, status, zero fill
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one request to the predicted deque and return the result it should give
  function automatic deque_result_t apply_request(deque_request_t req);
    deque_result_t res;
    int unsigned   pos;
    res = '0;
    res.status = rdq_pkg::ST_OK;
    pos = req.position;
    case (req.kind)
      rdq_pkg::KIND_ADD_BACK: begin
        if (deque_contents.size() >= ring_capacity) deque_contents.delete(0);
        deque_contents.insert(deque_contents.size(), req.value);
      end
      rdq_pkg::KIND_ADD_FRONT: begin
        if (deque_contents.size() >= ring_capacity)
          deque_contents.delete(deque_contents.size() - 1);
        deque_contents.insert(0, req.value);
      end
      rdq_pkg::KIND_DROP_BACK: begin
        if (deque_contents.size() == 0) res.status = rdq_pkg::ST_EMPTY;
        else deque_contents.delete(deque_contents.size() - 1);
      end
      rdq_pkg::KIND_DROP_FRONT: begin
        if (deque_contents.size() == 0) res.status = rdq_pkg::ST_EMPTY;
        else deque_contents.delete(0);
      end
      rdq_pkg::KIND_INSERT: begin
        if (pos > deque_contents.size()) begin
          res.status = rdq_pkg::ST_OUT_RANGE;
        end else begin
          // full: drop the front first, the new entry slides one place towards it
          if (deque_contents.size() >= ring_capacity) begin
            deque_contents.delete(0);
            if (pos > 0) pos = pos - 1;
          end
          deque_contents.insert(pos, req.value);
        end
      end
      rdq_pkg::KIND_DELETE: begin
        if (deque_contents.size() == 0) res.status = rdq_pkg::ST_EMPTY;
        else if (pos >= deque_contents.size()) res.status = rdq_pkg::ST_OUT_RANGE;
        else deque_contents.delete(pos);
      end
      rdq_pkg::KIND_READ: begin
        if (pos >= deque_contents.size()) res.status = rdq_pkg::ST_OUT_RANGE;
        else res.read_data = deque_contents[pos];
      end
      default: ;
    endcase
    res.fill_count = CNT_W'(deque_contents.size());
    res.is_empty   = (deque_contents.size() == 0);
    res.is_full    = (deque_contents.size() == ring_capacity);
    return res;
  endfunction

  // Driver: predict on each accepted request, then offer the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        awaited_results.insert(awaited_results.size(), apply_request(on_offer));
      if (!in_tvalid || in_tready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_offer = pending_requests[0];
          pending_requests.delete(0);
          in_tvalid <= 1'b1;
          in_tdata  <= {{(IN_W - DATA_W - CNT_W){1'b0}}, on_offer.position, on_offer.value};
          in_tuser  <= on_offer.kind;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: long hold-off on request, otherwise random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_seen  <= 1'b0;
      hold_left  <= 0;
    end else if (hold_request != hold_seen) begin
      hold_seen  <= hold_request;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic report_mismatch(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    fail_count++;
  endtask

  // Monitor: check each accepted result against the oldest expectation
  always @(posedge clk) begin
    deque_result_t want;
    deque_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.read_data  = out_tdata[DATA_W-1:0];
      got.fill_count = out_tdata[DATA_W +: CNT_W];
      got.is_empty   = out_tdata[DATA_W + CNT_W];
      got.is_full    = out_tdata[DATA_W + CNT_W + 1];
      got.status     = out_tdata[DATA_W + CNT_W + 2 +: rdq_pkg::STATUS_W];
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        fail_count++;
      end else begin
        want = awaited_results[0];
        awaited_results.delete(0);
        if (got.read_data !== want.read_data)
          report_mismatch("read_data", want.read_data, got.read_data);
        if (got.fill_count !== want.fill_count)
          report_mismatch("fill_count", DATA_W'(want.fill_count), DATA_W'(got.fill_count));
        if (got.is_empty !== want.is_empty)
          report_mismatch("is_empty", DATA_W'(want.is_empty), DATA_W'(got.is_empty));
        if (got.is_full !== want.is_full)
          report_mismatch("is_full", DATA_W'(want.is_full), DATA_W'(got.is_full));
        if (got.status !== want.status)
          report_mismatch("status", DATA_W'(want.status), DATA_W'(got.status));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic queue_request(logic [rdq_pkg::KIND_W-1:0] kind, logic [DATA_W-1:0] value,
                               logic [CNT_W-1:0] position);
    deque_request_t req;
    req.kind     = kind;
    req.value    = value;
    req.position = position;
    pending_requests.insert(pending_requests.size(), req);
  endtask

  // Hold until every request is taken and every result seen, then let the block settle
  task automatic wait_idle();
    @(negedge clk);
    while (pending_requests.size() != 0 || in_tvalid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CNT_W-1:0] setting);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= setting;
    ring_capacity = (setting == 0) ? 1 : (setting > DEPTH) ? DEPTH : setting;
    deque_contents.delete();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Random requests that swing between filling and draining, positions mostly in range
  task automatic queue_random(int unsigned count);
    int unsigned                fill;
    int unsigned                pos;
    int unsigned                pick;
    logic [rdq_pkg::KIND_W-1:0] kind;
    logic [DATA_W-1:0]          value;
    bit                         grow;
    fill = deque_contents.size();
    grow = 1'b1;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 30 == 0) grow = $urandom_range(1);
      pick = $urandom_range(99);
      if (pick == 0) kind = KIND_UNUSED;
      else if (pick < 16) kind = rdq_pkg::KIND_READ;
      else if ($urandom_range(99) < (grow ? 75 : 25)) begin
        case ($urandom_range(2))
          0:       kind = rdq_pkg::KIND_ADD_BACK;
          1:       kind = rdq_pkg::KIND_ADD_FRONT;
          default: kind = rdq_pkg::KIND_INSERT;
        endcase
      end else begin
        case ($urandom_range(2))
          0:       kind = rdq_pkg::KIND_DROP_BACK;
          1:       kind = rdq_pkg::KIND_DROP_FRONT;
          default: kind = rdq_pkg::KIND_DELETE;
        endcase
      end
      if ($urandom_range(9) < 8)
        pos = (kind == rdq_pkg::KIND_INSERT) ? $urandom_range(fill, 0)
                                             : (fill != 0 ? $urandom_range(fill - 1, 0) : 0);
      else
        pos = $urandom_range(DEPTH, 0);
      case ($urandom_range(19))
        0:       value = '0;
        1:       value = '1;
        default: value = $urandom;
      endcase
      queue_request(kind, value, CNT_W'(pos));
      // track the fill level the block will reach
      case (kind) inside
        rdq_pkg::KIND_ADD_BACK, rdq_pkg::KIND_ADD_FRONT:
          if (fill < ring_capacity) fill++;
        rdq_pkg::KIND_DROP_BACK, rdq_pkg::KIND_DROP_FRONT:
          if (fill != 0) fill--;
        rdq_pkg::KIND_INSERT:
          if (pos <= fill && fill < ring_capacity) fill++;
        rdq_pkg::KIND_DELETE:
          if (pos < fill) fill--;
        default: ;
      endcase
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty-buffer errors, appends and shifting at the reset capacity
    send_idle_pct  = 6;
    recv_stall_pct = 6;
    queue_request(rdq_pkg::KIND_READ,       '0, 0);
    queue_request(rdq_pkg::KIND_DROP_BACK,  '0, 0);
    queue_request(rdq_pkg::KIND_DROP_FRONT, '0, 0);
    queue_request(rdq_pkg::KIND_DELETE,     '0, 0);
    queue_request(rdq_pkg::KIND_INSERT,     32'h1111_1111, 1);
    queue_request(rdq_pkg::KIND_INSERT,     '0, 0);
    queue_request(rdq_pkg::KIND_ADD_BACK,   '1, 0);
    queue_request(rdq_pkg::KIND_ADD_FRONT,  32'h1234_5678, 0);
    queue_request(rdq_pkg::KIND_INSERT,     32'ha5a5_a5a5, 3);
    queue_request(rdq_pkg::KIND_INSERT,     32'h5a5a_5a5a, 1);
    queue_request(rdq_pkg::KIND_READ,       '0, 4);
    queue_request(rdq_pkg::KIND_READ,       '0, 5);
    queue_request(rdq_pkg::KIND_READ,       '0, 16);
    queue_request(rdq_pkg::KIND_DELETE,     '0, 5);
    queue_request(rdq_pkg::KIND_DELETE,     '0, 1);
    queue_request(KIND_UNUSED,              '1, 31);
    queue_request(rdq_pkg::KIND_DROP_BACK,  '0, 0);
    queue_request(rdq_pkg::KIND_DROP_FRONT, '0, 0);
    wait_idle();

    // zero capacity is taken as one: every push and insert after the first overflows
    write_capacity(0);
    queue_request(rdq_pkg::KIND_ADD_BACK,  32'hdead_beef, 0);
    queue_request(rdq_pkg::KIND_ADD_BACK,  32'h0bad_f00d, 0);
    queue_request(rdq_pkg::KIND_ADD_FRONT, 32'hcafe_0001, 0);
    queue_request(rdq_pkg::KIND_INSERT,    32'hcafe_0002, 0);
    queue_request(rdq_pkg::KIND_INSERT,    32'hcafe_0003, 1);
    queue_request(rdq_pkg::KIND_READ,      '0, 0);
    queue_request(rdq_pkg::KIND_DELETE,    '0, 0);
    wait_idle();

    // random phases over capacities and idling patterns
    for (int ph = 0; ph < 8; ph++) begin
      write_capacity(PHASE_CAPS[ph*CNT_W +: CNT_W]);
      case (ph % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
      endcase
      queue_random(PHASE_ITEMS);
      // back up the block with a long receiver hold-off while requests keep coming
      if (ph == 0) hold_request = ~hold_request;
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
